/* hw/rtl/pcs_pkg.sv */
package pcs_pkg;

  // fixed field widths
  localparam int CUBE_W      = 32;
  localparam int OUT_W       = 62;
  localparam int MAX_VARS    = 16;
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // input item modes
  localparam logic [1:0] MODE_LOAD_OUTER = 2'd0;
  localparam logic [1:0] MODE_LOAD_INNER = 2'd1;
  localparam logic [1:0] MODE_RUN        = 2'd2;

  // cube symbols
  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;
  localparam logic [1:0] SYM_DASH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SUB_POSITION = 2'd0;
  localparam logic [1:0] CFG_OUTER_VARS   = 2'd1;
  localparam logic [1:0] CFG_INNER_VARS   = 2'd2;

  // one stored table line
  typedef struct packed {
    logic              value;
    logic [CUBE_W-1:0] cube;
  } line_t;

  // run settings, already clamped
  typedef struct packed {
    logic [3:0] pos;
    logic [4:0] ov;
    logic [4:0] iv;
  } run_cfg_t;

  // variable count forced into 1..MAX_VARS
  function automatic logic [4:0] clamp_vars(logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) r = 5'd1;
    else if (v > 5'(MAX_VARS)) r = 5'(MAX_VARS);
    return r;
  endfunction

  // mask over n 2-bit symbols
  function automatic logic [CUBE_W-1:0] sym_mask(logic [4:0] n);
    logic [CUBE_W-1:0] m;
    if (n >= 5'(MAX_VARS)) m = '1;
    else m = (CUBE_W'(1) << {n, 1'b0}) - CUBE_W'(1);
    return m;
  endfunction

endpackage

/* hw/rtl/pcs_in_if.sv */
interface pcs_in_if import pcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [CUBE_W-1:0] cube_in;
  logic              value_in;

  modport source (output valid, output mode, output cube_in, output value_in, input ready);
  modport sink (input valid, input mode, input cube_in, input value_in, output ready);
endinterface

/* hw/rtl/pcs_out_if.sv */
interface pcs_out_if import pcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cube_out;
  logic             value_out;
  logic             last_of_run;

  modport source (output valid, output cube_out, output value_out, output last_of_run,
                  input ready);
  modport sink (input valid, input cube_out, input value_out, input last_of_run,
                output ready);
endinterface

/* hw/rtl/pcs_line_mem.sv */
module pcs_line_mem import pcs_pkg::*; #(
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  line_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output line_t         rdata
);

  line_t mem_r [DEPTH];
  line_t rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/pcs_run_ctrl.sv */
module pcs_run_ctrl import pcs_pkg::*; #(
  parameter int OUTER_LINES = 8,
  parameter int INNER_LINES = 8,
  localparam int OAW = (OUTER_LINES > 1) ? $clog2(OUTER_LINES) : 1,
  localparam int OCW = $clog2(OUTER_LINES + 1),
  localparam int IAW = (INNER_LINES > 1) ? $clog2(INNER_LINES) : 1,
  localparam int ICW = $clog2(INNER_LINES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  run_cfg_t        run_cfg,
  input  logic [OCW-1:0]  outer_count,
  input  logic [ICW-1:0]  inner_count,
  output logic            idle,
  output logic            o_re,
  output logic [OAW-1:0]  o_raddr,
  input  line_t           o_rdata,
  output logic            i_re,
  output logic [IAW-1:0]  i_raddr,
  input  line_t           i_rdata,
  pcs_out_if.source       out_ch
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_RD  = 4'd1;
  localparam logic [3:0] S_A_CHK = 4'd2;
  localparam logic [3:0] S_K_RD  = 4'd3;
  localparam logic [3:0] S_K_CHK = 4'd4;
  localparam logic [3:0] S_B_RD  = 4'd5;
  localparam logic [3:0] S_B_CHK = 4'd6;
  localparam logic [3:0] S_DASH  = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [1:0]           g_r, g_nxt;
  logic [OCW-1:0]       i_r, i_nxt;
  logic [OAW-1:0]       k_r, k_nxt;
  logic [ICW-1:0]       j_r, j_nxt;
  logic [OCW-1:0]       n_out_r, n_out_nxt;
  logic [ICW-1:0]       n_in_r, n_in_nxt;
  run_cfg_t             cfg_r, cfg_nxt;
  logic [CUBE_W-1:0]    oc_r, oc_nxt;
  logic [OUT_W-1:0]     base_r, base_nxt;
  logic                 fv_r, fv_nxt;
  logic [RES_CNT_W-1:0] res_n_r, res_n_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [OUT_W-1:0]     pend_cube_r, pend_cube_nxt;
  logic                 pend_value_r, pend_value_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_cube_r, out_cube_nxt;
  logic                 out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [CUBE_W-1:0] omask, imask, pmask, smask;
  logic [4:0]        suf_n;
  logic [1:0]        a_sym;
  logic [CUBE_W-1:0] pre_part, upper_part, ins_part;
  logic [5:0]        upper_sh;
  logic [5:0]        p_plus_iv;
  logic [OUT_W-1:0]  base_calc, emit_cube;
  logic              out_free, emit_ok, want_emit, emit, flush_out, load_out, last_res;

  // masks from the latched run settings
  assign suf_n = cfg_r.ov - {1'b0, cfg_r.pos} - 5'd1;
  assign omask = sym_mask(cfg_r.ov);
  assign imask = sym_mask(cfg_r.iv);
  assign pmask = sym_mask({1'b0, cfg_r.pos});
  assign smask = sym_mask(suf_n);

  // outer line prefix and shifted suffix
  assign a_sym      = o_rdata.cube[{cfg_r.pos, 1'b0} +: 2];
  assign pre_part   = o_rdata.cube & pmask;
  assign upper_sh   = {1'b0, cfg_r.pos, 1'b0} + 6'd2;
  assign upper_part = (o_rdata.cube >> upper_sh) & smask;
  assign p_plus_iv  = 6'(cfg_r.pos) + 6'(cfg_r.iv);
  assign base_calc  = OUT_W'(pre_part) | (OUT_W'(upper_part) << {p_plus_iv, 1'b0});

  // inner part dropped into the base
  assign ins_part  = (state_r == S_DASH) ? (32'hAAAA_AAAA & imask) : (i_rdata.cube & imask);
  assign emit_cube = base_r | (OUT_W'(ins_part) << {cfg_r.pos, 1'b0});

  // one pending result decides last_of_run
  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit_ok   = !pend_valid_r || out_free;
  assign want_emit = ((state_r == S_B_CHK) && (i_rdata.value == g_r[0])) || (state_r == S_DASH);
  assign emit      = want_emit && emit_ok;
  assign flush_out = (state_r == S_FLUSH) && pend_valid_r && out_free;
  assign load_out  = (emit && pend_valid_r) || flush_out;
  assign last_res  = (res_n_r == RES_CNT_W'(MAX_RESULTS - 1));

  // run sequencer
  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    n_out_nxt = n_out_r;
    n_in_nxt  = n_in_r;
    cfg_nxt   = cfg_r;
    oc_nxt    = oc_r;
    base_nxt  = base_r;
    fv_nxt    = fv_r;
    res_n_nxt = res_n_r;
    o_re      = 1'b0;
    o_raddr   = i_r[OAW-1:0];
    i_re      = 1'b0;
    i_raddr   = j_r[IAW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cfg_nxt   = run_cfg;
          n_out_nxt = outer_count;
          n_in_nxt  = inner_count;
          g_nxt     = SYM_ZERO;
          i_nxt     = '0;
          res_n_nxt = '0;
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: begin
        if (i_r < n_out_r) begin
          o_re      = 1'b1;
          state_nxt = S_A_CHK;
        end else if (g_r == SYM_DASH) begin
          state_nxt = S_FLUSH;
        end else begin
          g_nxt = g_r + 2'd1;
          i_nxt = '0;
        end
      end
      S_A_CHK: begin
        if (a_sym == g_r) begin
          oc_nxt    = o_rdata.cube;
          base_nxt  = base_calc;
          k_nxt     = '0;
          state_nxt = S_K_RD;
        end else begin
          i_nxt     = i_r + OCW'(1);
          state_nxt = S_A_RD;
        end
      end
      S_K_RD: begin
        o_re      = 1'b1;
        o_raddr   = k_r;
        state_nxt = S_K_CHK;
      end
      S_K_CHK: begin
        // earliest identical line; the line itself ends the search
        if (((o_rdata.cube ^ oc_r) & omask) == '0) begin
          fv_nxt    = o_rdata.value;
          j_nxt     = '0;
          state_nxt = (g_r == SYM_DASH) ? S_DASH : S_B_RD;
        end else begin
          k_nxt     = k_r + OAW'(1);
          state_nxt = S_K_RD;
        end
      end
      S_B_RD: begin
        if (j_r < n_in_r) begin
          i_re      = 1'b1;
          state_nxt = S_B_CHK;
        end else begin
          i_nxt     = i_r + OCW'(1);
          state_nxt = S_A_RD;
        end
      end
      S_B_CHK: begin
        if (!want_emit) begin
          j_nxt     = j_r + ICW'(1);
          state_nxt = S_B_RD;
        end else if (emit_ok) begin
          j_nxt     = j_r + ICW'(1);
          res_n_nxt = res_n_r + RES_CNT_W'(1);
          state_nxt = last_res ? S_FLUSH : S_B_RD;
        end
      end
      S_DASH: begin
        if (emit_ok) begin
          i_nxt     = i_r + OCW'(1);
          res_n_nxt = res_n_r + RES_CNT_W'(1);
          state_nxt = last_res ? S_FLUSH : S_A_RD;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r || out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // pending slot and output register
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_cube_nxt  = pend_cube_r;
    pend_value_nxt = pend_value_r;
    out_valid_nxt  = out_valid_r;
    out_cube_nxt   = out_cube_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_cube_nxt  = pend_cube_r;
      out_value_nxt = pend_value_r;
      out_last_nxt  = flush_out;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      pend_valid_nxt = 1'b1;
      pend_cube_nxt  = emit_cube;
      pend_value_nxt = fv_r;
    end else if (flush_out) begin
      pend_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // run datapath
  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    j_r          <= j_nxt;
    n_out_r      <= n_out_nxt;
    n_in_r       <= n_in_nxt;
    cfg_r        <= cfg_nxt;
    oc_r         <= oc_nxt;
    base_r       <= base_nxt;
    fv_r         <= fv_nxt;
    res_n_r      <= res_n_nxt;
    pend_cube_r  <= pend_cube_nxt;
    pend_value_r <= pend_value_nxt;
    out_cube_r   <= out_cube_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign idle               = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cube_out    = out_cube_r;
  assign out_ch.value_out   = out_value_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

/* hw/rtl/pla_cube_substitution_top.sv */
// channel   dir  handshake      payload
// in_ch     in   valid/ready    mode, cube_in, value_in
// out_ch    out  valid/ready    cube_out, value_out, last_of_run
// cfg_*     in   cfg_we         cfg_index, cfg_wdata
//
// a load item writes one line into the outer or inner table memory, unless that table is full
// a run blocks the input; each outer line is read once in each of the three groups; a
//   matching line adds the identical-line search and a read of every inner line (none for
//   a dash line), all through the single read port of each table memory
// no item is accepted while a run is in progress; loads are taken while the last result waits
// a stalled output holds the sequencer in place; rst_n is synchronous and clears control state
module pla_cube_substitution_top import pcs_pkg::*; #(
  parameter int OUTER_LINES = 8,
  parameter int INNER_LINES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pcs_in_if.sink     in_ch,
  pcs_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int OAW = (OUTER_LINES > 1) ? $clog2(OUTER_LINES) : 1;
  localparam int OCW = $clog2(OUTER_LINES + 1);
  localparam int IAW = (INNER_LINES > 1) ? $clog2(INNER_LINES) : 1;
  localparam int ICW = $clog2(INNER_LINES + 1);

  logic [3:0]     sub_position_r;
  logic [4:0]     outer_vars_r;
  logic [4:0]     inner_vars_r;
  logic [OCW-1:0] outer_count_r;
  logic [ICW-1:0] inner_count_r;

  run_cfg_t       run_cfg;
  line_t          line_in, o_rdata, i_rdata;
  logic           in_acc, load_outer, load_inner, run_start, ctrl_idle;
  logic           o_re, i_re;
  logic [OAW-1:0] o_raddr;
  logic [IAW-1:0] i_raddr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_position_r <= 4'd0;
      outer_vars_r   <= 5'd1;
      inner_vars_r   <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SUB_POSITION: sub_position_r <= cfg_wdata[3:0];
        CFG_OUTER_VARS:   outer_vars_r   <= cfg_wdata;
        CFG_INNER_VARS:   inner_vars_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped run settings
  always_comb begin
    run_cfg.ov  = clamp_vars(outer_vars_r);
    run_cfg.iv  = clamp_vars(inner_vars_r);
    run_cfg.pos = ({1'b0, sub_position_r} > (run_cfg.ov - 5'd1)) ?
                  4'(run_cfg.ov - 5'd1) : sub_position_r;
  end

  // input item decode
  assign in_ch.ready = ctrl_idle;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_outer  = in_acc && (in_ch.mode == MODE_LOAD_OUTER) &&
                       (outer_count_r < OCW'(OUTER_LINES));
  assign load_inner  = in_acc && (in_ch.mode == MODE_LOAD_INNER) &&
                       (inner_count_r < ICW'(INNER_LINES));
  assign run_start   = in_acc && (in_ch.mode == MODE_RUN);
  assign line_in     = '{value: in_ch.value_in, cube: in_ch.cube_in};

  // fill counts, both tables empty after a run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_count_r <= '0;
      inner_count_r <= '0;
    end else if (run_start) begin
      outer_count_r <= '0;
      inner_count_r <= '0;
    end else begin
      if (load_outer) outer_count_r <= outer_count_r + OCW'(1);
      if (load_inner) inner_count_r <= inner_count_r + ICW'(1);
    end
  end

  // table memories
  pcs_line_mem #(.DEPTH(OUTER_LINES)) u_outer_mem (
    .clk   (clk),
    .we    (load_outer),
    .waddr (outer_count_r[OAW-1:0]),
    .wdata (line_in),
    .re    (o_re),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  pcs_line_mem #(.DEPTH(INNER_LINES)) u_inner_mem (
    .clk   (clk),
    .we    (load_inner),
    .waddr (inner_count_r[IAW-1:0]),
    .wdata (line_in),
    .re    (i_re),
    .raddr (i_raddr),
    .rdata (i_rdata)
  );

  // run sequencer and result stage
  pcs_run_ctrl #(
    .OUTER_LINES (OUTER_LINES),
    .INNER_LINES (INNER_LINES)
  ) u_run_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (run_start),
    .run_cfg     (run_cfg),
    .outer_count (outer_count_r),
    .inner_count (inner_count_r),
    .idle        (ctrl_idle),
    .o_re        (o_re),
    .o_raddr     (o_raddr),
    .o_rdata     (o_rdata),
    .i_re        (i_re),
    .i_raddr     (i_raddr),
    .i_rdata     (i_rdata),
    .out_ch      (out_ch)
  );

  // a run empties both tables and blocks the input
  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    run_start |=> (outer_count_r == '0) && (inner_count_r == '0) && !in_ch.ready)
    else $error("run did not clear tables or block input");

  // fill counts never pass capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (outer_count_r <= OCW'(OUTER_LINES)) && (inner_count_r <= ICW'(INNER_LINES)))
    else $error("table fill count beyond capacity");

  // an accepted outer load bumps the count by one
  a_outer_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_outer |=> outer_count_r == $past(outer_count_r) + OCW'(1))
    else $error("outer load did not advance fill count");

endmodule

/* dv/tb_pla_cube_substitution_top.sv */
module tb_pla_cube_substitution_top;
  import pcs_pkg::*;

  localparam int A_DEPTH       = 8;
  localparam int B_DEPTH       = 8;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 185;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] SYM_INVALID = 2'd3;

  // one composed line as it leaves the block
  typedef struct packed {
    logic [OUT_W-1:0] cube;
    logic             value;
    logic             last;
  } comp_line_t;

  // one row of the directed table: an item or a register write
  typedef struct packed {
    logic             is_cfg;
    logic [1:0]       sel;
    logic [31:0]      data;
    logic             value;
    logic             typed;
    logic [OUT_W-1:0] t_cube;
    logic             t_value;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_wdata;

  pcs_in_if  in_ch ();
  pcs_out_if out_ch ();

  pla_cube_substitution_top #(
    .OUTER_LINES(A_DEPTH),
    .INNER_LINES(B_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // shadow tables and registers
  logic [31:0] a_cube [A_DEPTH];
  logic        a_val  [A_DEPTH];
  int          a_count;
  logic [31:0] b_cube [B_DEPTH];
  logic        b_val  [B_DEPTH];
  int          b_count;
  logic [3:0]  pos_reg;
  logic [4:0]  ov_reg;
  logic [4:0]  iv_reg;

  comp_line_t run_lines[$];
  comp_line_t expected_lines[$];
  int         errors;
  bit         need_drain;
  bit         in_quiet;
  bit         out_quiet;
  int         out_hold;
  int         idle_cycles;

  // directed stimulus
  stim_row_t directed_rows [31] = '{
    // defaults after reset: one variable each side, position 0
    '{1'b0, MODE_LOAD_OUTER, 32'h0000_0000, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_INNER, 32'h0000_0001, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_RUN,        32'h0000_0000, 1'b0, 1'b1, 62'h1, 1'b1},
    // run on empty tables, then the unused mode
    '{1'b0, MODE_RUN,        32'hFFFF_FFFF, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_UNUSED,     32'hFFFF_FFFF, 1'b1, 1'b0, 62'h0, 1'b0},
    // widest cubes, last position, counts above range
    '{1'b1, CFG_SUB_POSITION, 32'd15, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b1, CFG_OUTER_VARS,   32'd31, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b1, CFG_INNER_VARS,   32'd31, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'hFFFF_FFFF, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h2AAA_AAAA, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'hAAAA_AAAA, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h2AAA_AAAA, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_INNER, 32'hFFFF_FFFF, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_INNER, 32'h0000_0000, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_INNER, 32'h5555_5555, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_RUN,        32'h0000_0000, 1'b0, 1'b0, 62'h0, 1'b0},
    // position past the outer width, inner count zero, outer table overfilled
    '{1'b1, CFG_SUB_POSITION, 32'd9, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b1, CFG_OUTER_VARS,   32'd4, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b1, CFG_INNER_VARS,   32'd0, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h0000_0000, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'hFFFF_FF40, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h0000_0080, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h0000_00C0, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h5555_5500, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h0000_005A, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h0000_0096, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h0000_001B, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_OUTER, 32'h0000_0044, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_INNER, 32'h0000_0003, 1'b1, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_LOAD_INNER, 32'hFFFF_FFFE, 1'b0, 1'b0, 62'h0, 1'b0},
    '{1'b0, MODE_RUN,        32'h1234_5678, 1'b1, 1'b0, 62'h0, 1'b0}
  };

  // variable count used by a run
  function automatic int fit_vars(logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > 5'(MAX_VARS)) return MAX_VARS;
    return int'(v);
  endfunction

  // low 2n bits set
  function automatic logic [63:0] span_mask(int n);
    if (n <= 0) return 64'd0;
    return (64'd1 << (2 * n)) - 64'd1;
  endfunction

  // update the shadow state for one accepted item; a run fills run_lines
  function automatic void substitute_item(logic [1:0] mode, logic [31:0] cube, logic val);
    int ov, iv, p, g, i, j, k;
    logic [63:0] omask, imask, pmask, smask, dash_part, oc, pre, suf, word;
    logic [1:0] sym;
    logic fv;
    run_lines.delete();
    case (mode)
      MODE_LOAD_OUTER: begin
        if (a_count < A_DEPTH) begin
          a_cube[a_count] = cube;
          a_val[a_count] = val;
          a_count++;
        end
      end
      MODE_LOAD_INNER: begin
        if (b_count < B_DEPTH) begin
          b_cube[b_count] = cube;
          b_val[b_count] = val;
          b_count++;
        end
      end
      MODE_RUN: begin
        ov = fit_vars(ov_reg);
        iv = fit_vars(iv_reg);
        p = int'(pos_reg);
        if (p > ov - 1) p = ov - 1;
        omask = span_mask(ov);
        imask = span_mask(iv);
        pmask = span_mask(p);
        smask = span_mask(ov - p - 1);
        dash_part = {32{SYM_DASH}} & imask;
        // groups by symbol at the position: zero, one, dash
        for (g = 0; g < 3; g++) begin
          for (i = 0; i < a_count; i++) begin
            oc = 64'(a_cube[i]);
            sym = oc[2*p +: 2];
            if (int'(sym) != g) continue;
            // value of the earliest identical outer line
            fv = 1'b0;
            for (k = 0; k < a_count; k++) begin
              if (((64'(a_cube[k]) ^ oc) & omask) == 64'd0) begin
                fv = a_val[k];
                break;
              end
            end
            pre = oc & pmask;
            suf = ((oc >> (2 * (p + 1))) & smask) << (2 * (p + iv));
            if (g < 2) begin
              for (j = 0; j < b_count; j++) begin
                if (int'(b_val[j]) != g) continue;
                if (run_lines.size() >= MAX_RESULTS) break;
                word = pre | ((64'(b_cube[j]) & imask) << (2 * p)) | suf;
                run_lines.push_back('{word[OUT_W-1:0], fv, 1'b0});
              end
            end else if (run_lines.size() < MAX_RESULTS) begin
              word = pre | (dash_part << (2 * p)) | suf;
              run_lines.push_back('{word[OUT_W-1:0], fv, 1'b0});
            end
          end
        end
        if (run_lines.size() > 0) run_lines[run_lines.size() - 1].last = 1'b1;
        a_count = 0;
        b_count = 0;
      end
      default: ;
    endcase
  endfunction

  // mostly valid symbols, now and then a fully random word
  function automatic logic [31:0] rand_cube();
    logic [31:0] c;
    int s, r;
    if ($urandom_range(0, 7) == 0) return $urandom();
    for (s = 0; s < MAX_VARS; s++) begin
      r = $urandom_range(0, 19);
      c[2*s +: 2] = (r < 6) ? SYM_ZERO : (r < 12) ? SYM_ONE : (r < 19) ? SYM_DASH : SYM_INVALID;
    end
    return c;
  endfunction

  // variable count with the extremes weighted in
  function automatic logic [4:0] pick_vars();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd31;
      2: return 5'd16;
      3: return 5'd1;
      default: return 5'($urandom_range(2, 15));
    endcase
  endfunction

  // drive one item and wait for it to be taken
  task automatic send_item(input logic [1:0] mode, input logic [31:0] cube, input logic val,
                           input logic typed, input logic [OUT_W-1:0] t_cube,
                           input logic t_value);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 12);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.cube_in  <= cube;
    in_ch.value_in <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    need_drain = 1'b1;
    substitute_item(mode, cube, val);
    if (typed) expected_lines.push_back('{t_cube, t_value, 1'b1});
    else foreach (run_lines[n]) expected_lines.push_back(run_lines[n]);
  endtask

  // register write; the strobe is dropped by the next item
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_SUB_POSITION: pos_reg = data[3:0];
      CFG_OUTER_VARS:   ov_reg = data;
      CFG_INNER_VARS:   iv_reg = data;
      default: ;
    endcase
  endtask

  // wait for all lines, then let a run with no output finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    need_drain = 1'b0;
  endtask

  // result side: compare and draw the next stall
  always @(posedge clk) begin : result_check
    comp_line_t want;
    int hold;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t: unexpected line, expected none actual cube %h value %b last %b",
                 $time, out_ch.cube_out, out_ch.value_out, out_ch.last_of_run);
      end else begin
        want = expected_lines.pop_front();
        if (out_ch.cube_out !== want.cube) begin
          errors++;
          $display("%0t: cube_out expected %h actual %h", $time, want.cube, out_ch.cube_out);
        end
        if (out_ch.value_out !== want.value) begin
          errors++;
          $display("%0t: value_out expected %b actual %b", $time, want.value,
                   out_ch.value_out);
        end
        if (out_ch.last_of_run !== want.last) begin
          errors++;
          $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                   out_ch.last_of_run);
        end
      end
      if ($urandom_range(0, 23) == 0) out_quiet = !out_quiet;
      hold = out_quiet ? 0 : $urandom_range(0, 12);
      out_hold <= hold;
      out_ch.ready <= (hold == 0);
    end else if (!out_ch.ready) begin
      if (out_hold <= 1) out_ch.ready <= 1'b1;
      out_hold <= out_hold - 1;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("pla_cube_substitution_top: mismatch");
        $finish;
      end
    end
  end

  // reset, directed table, then random runs
  initial begin : stimulus
    stim_row_t row;
    int items, kind, na, nb;
    logic [1:0] md;
    logic [31:0] cube;
    logic [31:0] seq_outer[$];
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_SUB_POSITION;
    cfg_wdata      <= 5'd0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_LOAD_OUTER;
    in_ch.cube_in  <= 32'd0;
    in_ch.value_in <= 1'b0;
    pos_reg = 4'd0;
    ov_reg = 5'd1;
    iv_reg = 5'd1;
    a_count = 0;
    b_count = 0;
    errors = 0;
    need_drain = 1'b0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.is_cfg) begin
        if (need_drain) settle();
        write_reg(row.sel, row.data[4:0]);
      end else begin
        send_item(row.sel, row.data, row.value, row.typed, row.t_cube, row.t_value);
      end
    end

    // random part: a new setting, then a few load-and-run sequences
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if (need_drain) settle();
      write_reg(CFG_SUB_POSITION, ($urandom_range(0, 3) == 0) ? 5'd15 : 5'($urandom_range(0, 31)));
      write_reg(CFG_OUTER_VARS, pick_vars());
      write_reg(CFG_INNER_VARS, pick_vars());
      repeat (4) begin
        in_quiet = ($urandom_range(0, 4) == 0);
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          // noise with any mode and raw words
          repeat ($urandom_range(1, 3)) begin
            md = 2'($urandom_range(0, 3));
            send_item(md, $urandom(), 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
            if (md != MODE_UNUSED) items++;
          end
        end else begin
          na = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 5);
          nb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 5);
          seq_outer.delete();
          // interleaved loads, some outer lines repeated
          while (na + nb > 0) begin
            if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 0)) begin
              if (seq_outer.size() > 0 && $urandom_range(0, 3) == 0)
                cube = seq_outer[$urandom_range(0, seq_outer.size() - 1)];
              else
                cube = rand_cube();
              seq_outer.push_back(cube);
              send_item(MODE_LOAD_OUTER, cube, 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
              na--;
            end else begin
              send_item(MODE_LOAD_INNER, rand_cube(), 1'($urandom_range(0, 1)), 1'b0, '0,
                        1'b0);
              nb--;
            end
            items++;
          end
          // a broken sequence leaves its loads for the next run
          if (kind != 1) begin
            send_item(MODE_RUN, $urandom(), 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
            items++;
            if ($urandom_range(0, 4) == 0) begin
              in_ch.valid <= 1'b0;
              do @(posedge clk); while (expected_lines.size() != 0);
            end
          end
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("pla_cube_substitution_top: match");
    end else begin
      $display("pla_cube_substitution_top: mismatch");
    end
    $finish;
  end

endmodule
